// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL; all are clocked on clk, off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational invariant checked at every edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in this cycle implies a result in the next one.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/crde_pkg.sv =====
package crde_pkg;

  localparam logic [22:0] BUFFER_OFFSET = 23'd8;
  localparam logic [11:0] MAX_WIDTH     = 12'd2048;
  localparam logic [11:0] MAX_HEIGHT    = 12'd2048;

  localparam logic [11:0] RST_CLIP_LEFT   = 12'd0;
  localparam logic [11:0] RST_CLIP_TOP    = 12'd0;
  localparam logic [11:0] RST_CLIP_RIGHT  = 12'd800;
  localparam logic [11:0] RST_CLIP_BOTTOM = 12'd480;
  localparam logic [11:0] RST_LINE_PITCH  = 12'd800;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
  localparam logic [2:0] REG_CLIP_RIGHT  = 3'd2;
  localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [2:0] REG_LINE_PITCH  = 3'd4;

  // Input action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Edge bit positions
  localparam int EDGE_TOP    = 0;
  localparam int EDGE_BOTTOM = 1;
  localparam int EDGE_LEFT   = 2;
  localparam int EDGE_RIGHT  = 3;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_FILL   = 6'b000010,
    PH_TOP    = 6'b000100,
    PH_BOTTOM = 6'b001000,
    PH_LEFT   = 6'b010000,
    PH_RIGHT  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [11:0] clip_left;
    logic [11:0] clip_top;
    logic [11:0] clip_right;
    logic [11:0] clip_bottom;
    logic [11:0] line_pitch;
  } cfg_t;

  typedef struct packed {
    logic   load;      // latch a new rectangle from the input word
    logic   cur_load;  // load cursors for the start of phase target
    phase_t target;
    logic   inc_x;
    logic   inc_y;
    logic   wrap_x;    // back to col_low, next row
    logic   capture;   // load output registers
    logic   write;     // output word carries a write
  } dp_cmd_t;

  typedef struct packed {
    logic       fill_ok;  // start word gives a non-empty fill
    logic [3:0] edges;    // start word: edges to draw, clipped and non-empty
    logic       x_last;
    logic       y_last;
  } dp_status_t;

endpackage

// ===== rtl/clipped_rectangle_draw_engine_core.sv =====
// Result: a result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one input word per cycle; in_ready stays high while the output
//   register is empty or its result is taken in the same cycle, so a stalled
//   result holds the input for as long as out_ready stays low.
// Reset: synchronous, active high rst; clip window returns to 0,0..800,480,
//   line_pitch to 800, no command running and no result pending.
module clipped_rectangle_draw_engine_core
  import crde_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Input word channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [12:0] corner_x,
  input  logic signed [12:0] corner_y,
  input  logic [11:0]        span_x,
  input  logic [11:0]        span_y,
  input  logic               solid,
  input  logic [23:0]        paint,
  // Result word channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_valid,
  output logic [22:0]        word_address,
  output logic [31:0]        pixel_word,
  output logic               finished,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Clip window and pitch; saturated on write, read back as stored
  crde_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: phase (fill or an edge: top, bottom, left or right), remaining edges, handshake
  crde_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .write_valid (write_valid),
    .finished    (finished),
    .status      (status),
    .cmd         (cmd)
  );

  // Clipping, cursor walk and address generation. The pitch is read live,
  // so a pitch change mid-command takes effect on the next write.
  crde_dp u_dp (
    .clk          (clk),
    .cfg          (cfg),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .span_x       (span_x),
    .span_y       (span_y),
    .solid        (solid),
    .paint        (paint),
    .cmd          (cmd),
    .status       (status),
    .word_address (word_address),
    .pixel_word   (pixel_word)
  );

endmodule

// ===== rtl/crde_regs.sv =====
module crde_regs
  import crde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0]  index;
  logic [11:0] value;
  logic [11:0] value_sat;
  logic        wr_en;

  assign index     = paddr[4:2];
  assign value     = pwdata[11:0];
  // both bounds are the same here; clamp against the height limit for y, the width limit for x and pitch
  assign wr_en     = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    value_sat = value;
    case (index)
      REG_CLIP_TOP, REG_CLIP_BOTTOM: begin
        if (value > MAX_HEIGHT) value_sat = MAX_HEIGHT;
      end
      default: begin
        if (value > MAX_WIDTH) value_sat = MAX_WIDTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left   <= RST_CLIP_LEFT;
      cfg.clip_top    <= RST_CLIP_TOP;
      cfg.clip_right  <= RST_CLIP_RIGHT;
      cfg.clip_bottom <= RST_CLIP_BOTTOM;
      cfg.line_pitch  <= RST_LINE_PITCH;
    end else if (wr_en) begin
      case (index)
        REG_CLIP_LEFT:   cfg.clip_left   <= value_sat;
        REG_CLIP_TOP:    cfg.clip_top    <= value_sat;
        REG_CLIP_RIGHT:  cfg.clip_right  <= value_sat;
        REG_CLIP_BOTTOM: cfg.clip_bottom <= value_sat;
        REG_LINE_PITCH:  cfg.line_pitch  <= value_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_CLIP_LEFT:   prdata = {20'd0, cfg.clip_left};
      REG_CLIP_TOP:    prdata = {20'd0, cfg.clip_top};
      REG_CLIP_RIGHT:  prdata = {20'd0, cfg.clip_right};
      REG_CLIP_BOTTOM: prdata = {20'd0, cfg.clip_bottom};
      REG_LINE_PITCH:  prdata = {20'd0, cfg.line_pitch};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/crde_dp.sv =====
module crde_dp
  import crde_pkg::*;
(
  input  logic               clk,
  input  cfg_t               cfg,
  input  logic signed [12:0] corner_x,
  input  logic signed [12:0] corner_y,
  input  logic [11:0]        span_x,
  input  logic [11:0]        span_y,
  input  logic               solid,
  input  logic [23:0]        paint,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic [22:0]        word_address,
  output logic [31:0]        pixel_word
);

  // Start-word clipping
  logic signed [13:0] xs, ys, xe, ye, cl, ct, cr, cb;
  logic signed [13:0] c_col_low, c_col_high, c_row_low, c_row_high;
  logic signed [13:0] xe_m1, ye_m1;
  logic               reject, cols_ok, rows_ok;
  logic [3:0]         raw_edges;

  // Latched rectangle
  logic [11:0] col_low, col_high, row_low, row_high;
  logic [11:0] top_row, bot_row, left_col, right_col;
  logic [31:0] latched_word;

  // Cursor
  logic [11:0] cursor_x, cursor_y, cursor_x_next, cursor_y_next;
  logic [11:0] s_col_low, s_row_low, s_top, s_bot, s_left, s_right;
  logic [12:0] x_inc, y_inc;

  logic [23:0] row_base;
  logic [22:0] addr;

  assign xs = {corner_x[12], corner_x};
  assign ys = {corner_y[12], corner_y};
  assign xe = xs + $signed({2'b00, span_x});
  assign ye = ys + $signed({2'b00, span_y});
  assign cl = $signed({2'b00, cfg.clip_left});
  assign ct = $signed({2'b00, cfg.clip_top});
  assign cr = $signed({2'b00, cfg.clip_right});
  assign cb = $signed({2'b00, cfg.clip_bottom});
  assign xe_m1 = xe - 14'sd1;
  assign ye_m1 = ye - 14'sd1;

  assign reject     = (xs >= cr) || (ys >= cb) || (xe < cl) || (ye < ct);
  assign c_col_low  = (xs > cl) ? xs : cl;
  assign c_col_high = (xe < cr) ? xe : cr;
  assign c_row_low  = (ys > ct) ? ys : ct;
  assign c_row_high = (ye < cb) ? ye : cb;
  assign cols_ok    = c_col_low < c_col_high;
  assign rows_ok    = c_row_low < c_row_high;

  // Drop an edge whose line falls outside the window
  assign raw_edges[EDGE_TOP]    = (ys >= ct) && cols_ok;
  assign raw_edges[EDGE_BOTTOM] = (ye <= cb) && (ye > ct) && cols_ok;
  assign raw_edges[EDGE_LEFT]   = (xs >= cl) && rows_ok;
  assign raw_edges[EDGE_RIGHT]  = (xe <= cr) && (xe > cl) && rows_ok;

  assign status.fill_ok = !reject && solid && cols_ok && rows_ok;
  assign status.edges   = (reject || solid) ? 4'd0 : raw_edges;

  assign x_inc = {1'b0, cursor_x} + 13'd1;
  assign y_inc = {1'b0, cursor_y} + 13'd1;
  assign status.x_last = x_inc >= {1'b0, col_high};
  assign status.y_last = y_inc >= {1'b0, row_high};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_low      <= c_col_low[11:0];
      col_high     <= c_col_high[11:0];
      row_low      <= c_row_low[11:0];
      row_high     <= c_row_high[11:0];
      top_row      <= ys[11:0];
      bot_row      <= ye_m1[11:0];
      left_col     <= xs[11:0];
      right_col    <= xe_m1[11:0];
      latched_word <= {paint, 8'd0};
    end
  end

  // Cursor sources: fresh values on a start word, latched ones otherwise
  assign s_col_low = cmd.load ? c_col_low[11:0] : col_low;
  assign s_row_low = cmd.load ? c_row_low[11:0] : row_low;
  assign s_top     = cmd.load ? ys[11:0]        : top_row;
  assign s_bot     = cmd.load ? ye_m1[11:0]     : bot_row;
  assign s_left    = cmd.load ? xs[11:0]        : left_col;
  assign s_right   = cmd.load ? xe_m1[11:0]     : right_col;

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    if (cmd.cur_load) begin
      case (cmd.target)
        PH_FILL: begin
          cursor_x_next = s_col_low;
          cursor_y_next = s_row_low;
        end
        PH_TOP: begin
          cursor_x_next = s_col_low;
          cursor_y_next = s_top;
        end
        PH_BOTTOM: begin
          cursor_x_next = s_col_low;
          cursor_y_next = s_bot;
        end
        PH_LEFT: begin
          cursor_x_next = s_left;
          cursor_y_next = s_row_low;
        end
        PH_RIGHT: begin
          cursor_x_next = s_right;
          cursor_y_next = s_row_low;
        end
        default: ;
      endcase
    end else if (cmd.wrap_x) begin
      cursor_x_next = col_low;
      cursor_y_next = y_inc[11:0];
    end else if (cmd.inc_x) begin
      cursor_x_next = x_inc[11:0];
    end else if (cmd.inc_y) begin
      cursor_y_next = y_inc[11:0];
    end
  end

  always_ff @(posedge clk) begin
    cursor_x <= cursor_x_next;
    cursor_y <= cursor_y_next;
  end

  assign row_base = cfg.line_pitch * cursor_y;
  assign addr     = row_base[22:0] + {11'd0, cursor_x} + BUFFER_OFFSET;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_address <= cmd.write ? addr : 23'd0;
      pixel_word   <= cmd.write ? latched_word : 32'd0;
    end
  end

endmodule

// ===== rtl/crde_ctrl.sv =====
`include "assert_macros.svh"

module crde_ctrl
  import crde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       write_valid,
  output logic       finished,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  phase_t     state, state_next;
  logic [3:0] pending, pending_next;
  logic       accept;
  logic       seek_go;
  logic [3:0] seek_mask;
  phase_t     seek_phase;

  // Pick the first edge still to draw; order is top, bottom, left, right
  function automatic phase_t first_edge(input logic [3:0] m);
    phase_t p;
    p = PH_IDLE;
    if (m[EDGE_TOP])         p = PH_TOP;
    else if (m[EDGE_BOTTOM]) p = PH_BOTTOM;
    else if (m[EDGE_LEFT])   p = PH_LEFT;
    else if (m[EDGE_RIGHT])  p = PH_RIGHT;
    return p;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    pending_next = pending;
    cmd          = '0;
    cmd.target   = PH_IDLE;
    seek_go      = 1'b0;
    seek_mask    = pending;
    cmd.capture  = accept;

    if (accept) begin
      if (action == ACT_START) begin
        cmd.load     = 1'b1;
        pending_next = '0;
        if (status.fill_ok) begin
          state_next   = PH_FILL;
          cmd.cur_load = 1'b1;
          cmd.target   = PH_FILL;
        end else begin
          seek_go   = 1'b1;
          seek_mask = status.edges;
        end
      end else begin
        cmd.write = (state != PH_IDLE);
        case (state)
          PH_FILL: begin
            if (!status.x_last) begin
              cmd.inc_x = 1'b1;
            end else if (!status.y_last) begin
              cmd.wrap_x = 1'b1;
            end else begin
              state_next = PH_IDLE;
            end
          end
          PH_TOP, PH_BOTTOM: begin
            if (status.x_last) seek_go = 1'b1;
            else cmd.inc_x = 1'b1;
          end
          PH_LEFT, PH_RIGHT: begin
            if (status.y_last) seek_go = 1'b1;
            else cmd.inc_y = 1'b1;
          end
          default: ;
        endcase
      end
    end

    seek_phase = first_edge(seek_mask);
    if (seek_go) begin
      state_next   = seek_phase;
      // clear the lowest set bit: that edge is now running
      pending_next = seek_mask & (seek_mask - 4'd1);
      cmd.cur_load = (seek_phase != PH_IDLE);
      cmd.target   = seek_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= PH_IDLE;
      pending     <= '0;
      out_valid   <= 1'b0;
      write_valid <= 1'b0;
      finished    <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      if (accept) begin
        out_valid   <= 1'b1;
        write_valid <= cmd.write;
        finished    <= (state_next == PH_IDLE);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_no_pending_edges, (state == PH_IDLE || state == PH_FILL) -> (pending == 4'd0), "edges pending outside outline mode")
  `ASSERT_NEXT(a_idle_advance, accept && action == ACT_ADVANCE && state == PH_IDLE, out_valid && finished && !write_valid, "advance while idle must finish without a write")
  `ASSERT_NEXT(a_start_no_write, accept && action == ACT_START, out_valid && !write_valid, "start word must not carry a write")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench
  import crde_pkg::*;
();

  // One input word and one result word, laid out field by field.
  typedef struct packed {
    logic               action;
    logic signed [12:0] cx;
    logic signed [12:0] cy;
    logic [11:0]        sx;
    logic [11:0]        sy;
    logic               solid;
    logic [23:0]        paint;
  } draw_word_t;

  typedef struct packed {
    logic        wv;
    logic [22:0] addr;
    logic [31:0] data;
    logic        fin;
  } pixel_result_t;

  // A directed row: the word, and a typed-in result where one is given.
  typedef struct packed {
    draw_word_t    word;
    logic          typed;
    pixel_result_t res;
  } stim_row_t;

  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_RUNS  = 9;
  localparam int WORDS_PER_RUN = 122;
  localparam pixel_result_t NO_RES = '0;

  // Clock, reset and every block input start at known values.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = ACT_START;
  logic signed [12:0] corner_x = '0;
  logic signed [12:0] corner_y = '0;
  logic [11:0]        span_x = '0;
  logic [11:0]        span_y = '0;
  logic               solid = 1'b0;
  logic [23:0]        paint = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               write_valid;
  logic [22:0]        word_address;
  logic [31:0]        pixel_word;
  logic               finished;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  clipped_rectangle_draw_engine_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .span_x       (span_x),
    .span_y       (span_y),
    .solid        (solid),
    .paint        (paint),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_valid  (write_valid),
    .word_address (word_address),
    .pixel_word   (pixel_word),
    .finished     (finished),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle rates in percent, changed between runs.
  int send_gap_pct   = 27;
  int recv_stall_pct = 66;

  // Expected result words, oldest first.
  pixel_result_t expected_pixels[$];
  stim_row_t     stim_table[$];

  int error_count  = 0;
  int words_in     = 0;
  int results_seen = 0;
  int writes_seen  = 0;
  int reg_writes   = 0;
  int stall_cycles = 0;

  // Shadow of the clip window and pitch, after saturation.
  int win_left, win_top, win_right, win_bottom, pitch;

  // Shadow of the drawing state.
  phase_t      draw_phase;
  int          pen_x, pen_y;
  int          col_lo, col_hi, row_lo, row_hi;
  int          r_left, r_right_end, r_top, r_bottom_end;
  logic [3:0]  edge_en;
  logic [31:0] fill_word;

  function automatic phase_t edge_phase(int k);
    case (k)
      EDGE_TOP:    return PH_TOP;
      EDGE_BOTTOM: return PH_BOTTOM;
      EDGE_LEFT:   return PH_LEFT;
      default:     return PH_RIGHT;
    endcase
  endfunction

  // Move to the first enabled, non-empty edge at or after the given edge; else go idle.
  function automatic void seek_edge_from(int first);
    bit found;
    found = 1'b0;
    draw_phase = PH_IDLE;
    for (int k = first; k <= EDGE_RIGHT; k++) begin
      if (!found && edge_en[k]) begin
        if (k == EDGE_TOP || k == EDGE_BOTTOM) begin
          if (col_lo < col_hi) begin
            pen_x = col_lo;
            pen_y = (k == EDGE_TOP) ? r_top : r_bottom_end - 1;
            found = 1'b1;
          end
        end else if (row_lo < row_hi) begin
          pen_y = row_lo;
          pen_x = (k == EDGE_LEFT) ? r_left : r_right_end - 1;
          found = 1'b1;
        end
        if (found) draw_phase = edge_phase(k);
      end
    end
  endfunction

  // Work out the result of one accepted word and advance the shadow state.
  function automatic pixel_result_t predict_pixel(draw_word_t w);
    pixel_result_t r;
    int xs, ys, xe, ye;
    logic [31:0] sum;
    r = '0;
    if (w.action == ACT_START) begin
      xs = int'($signed(w.cx));
      ys = int'($signed(w.cy));
      xe = xs + int'(w.sx);
      ye = ys + int'(w.sy);
      fill_word = {w.paint, 8'h00};
      r_left = xs;
      r_right_end = xe;
      r_top = ys;
      r_bottom_end = ye;
      draw_phase = PH_IDLE;
      edge_en = '0;
      col_lo = 0;
      col_hi = 0;
      row_lo = 0;
      row_hi = 0;
      pen_x = 0;
      pen_y = 0;
      // Drop a rectangle that lies wholly outside the window.
      if (!(xs >= win_right || ys >= win_bottom || xe < win_left || ye < win_top)) begin
        col_lo = (xs > win_left) ? xs : win_left;
        col_hi = (xe < win_right) ? xe : win_right;
        row_lo = (ys > win_top) ? ys : win_top;
        row_hi = (ye < win_bottom) ? ye : win_bottom;
        if (w.solid) begin
          if (col_lo < col_hi && row_lo < row_hi) begin
            pen_x = col_lo;
            pen_y = row_lo;
            draw_phase = PH_FILL;
          end
        end else begin
          // Keep only edges whose line lies inside the window.
          edge_en[EDGE_TOP]    = (ys >= win_top);
          edge_en[EDGE_BOTTOM] = (ye <= win_bottom) && (ye - 1 >= win_top);
          edge_en[EDGE_LEFT]   = (xs >= win_left);
          edge_en[EDGE_RIGHT]  = (xe <= win_right) && (xe - 1 >= win_left);
          seek_edge_from(EDGE_TOP);
        end
      end
    end else if (draw_phase != PH_IDLE) begin
      sum = BUFFER_OFFSET + pen_x + pitch * pen_y;
      r.wv = 1'b1;
      r.addr = sum[22:0];
      r.data = fill_word;
      case (draw_phase)
        PH_FILL: begin
          pen_x++;
          if (pen_x >= col_hi) begin
            pen_x = col_lo;
            pen_y++;
            if (pen_y >= row_hi) draw_phase = PH_IDLE;
          end
        end
        PH_TOP: begin
          pen_x++;
          if (pen_x >= col_hi) seek_edge_from(EDGE_BOTTOM);
        end
        PH_BOTTOM: begin
          pen_x++;
          if (pen_x >= col_hi) seek_edge_from(EDGE_LEFT);
        end
        PH_LEFT: begin
          pen_y++;
          if (pen_y >= row_hi) seek_edge_from(EDGE_RIGHT);
        end
        default: begin
          pen_y++;
          if (pen_y >= row_hi) seek_edge_from(EDGE_RIGHT + 1);
        end
      endcase
    end
    r.fin = (draw_phase == PH_IDLE);
    return r;
  endfunction

  function automatic draw_word_t mk_word(logic act, int cx, int cy, int sx, int sy,
                                         logic fill, logic [23:0] colour);
    draw_word_t w;
    w.action = act;
    w.cx = cx[12:0];
    w.cy = cy[12:0];
    w.sx = sx[11:0];
    w.sy = sy[11:0];
    w.solid = fill;
    w.paint = colour;
    return w;
  endfunction

  function automatic pixel_result_t mk_res(logic wv, int addr, logic [31:0] data, logic fin);
    pixel_result_t r;
    r.wv = wv;
    r.addr = addr[22:0];
    r.data = data;
    r.fin = fin;
    return r;
  endfunction

  // Offer one word, wait for it to be taken, and queue its expected result.
  // Valid stays high into the next word unless a gap is drawn.
  task automatic put_word(input draw_word_t w, input logic typed, input pixel_result_t typed_res);
    pixel_result_t pred;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    action   <= w.action;
    corner_x <= w.cx;
    corner_y <= w.cy;
    span_x   <= w.sx;
    span_y   <= w.sy;
    solid    <= w.solid;
    paint    <= w.paint;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_pixel(w);
    expected_pixels.push_back(typed ? typed_res : pred);
    words_in++;
  endtask

  // Drop valid and let every expected result come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access until pready.
  // Junk goes in the upper data bits; only the low 12 count.
  task automatic reg_write(input logic [2:0] idx, input logic [11:0] val);
    logic [31:0] d;
    int sat;
    d = $urandom;
    d[11:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CLIP_LEFT:   win_left   = int'((val > MAX_WIDTH)  ? MAX_WIDTH  : val);
      REG_CLIP_TOP:    win_top    = int'((val > MAX_HEIGHT) ? MAX_HEIGHT : val);
      REG_CLIP_RIGHT:  win_right  = int'((val > MAX_WIDTH)  ? MAX_WIDTH  : val);
      REG_CLIP_BOTTOM: win_bottom = int'((val > MAX_HEIGHT) ? MAX_HEIGHT : val);
      REG_LINE_PITCH: begin
        sat = int'((val > MAX_WIDTH) ? MAX_WIDTH : val);
        pitch = sat;
      end
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_window(input int l, input int t, input int r, input int b, input int p);
    reg_write(REG_CLIP_LEFT, l[11:0]);
    reg_write(REG_CLIP_TOP, t[11:0]);
    reg_write(REG_CLIP_RIGHT, r[11:0]);
    reg_write(REG_CLIP_BOTTOM, b[11:0]);
    reg_write(REG_LINE_PITCH, p[11:0]);
  endtask

  // Land a coordinate near one window edge, or somewhere inside.
  function automatic int near_edge(int lo, int hi);
    int v;
    case ($urandom_range(2))
      0:       v = lo + int'($urandom_range(16)) - 8;
      1:       v = hi + int'($urandom_range(16)) - 8;
      default: v = (hi > lo) ? lo + int'($urandom_range(hi - lo - 1)) : lo;
    endcase
    return v;
  endfunction

  function automatic draw_word_t rand_rect();
    draw_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.action = ACT_START;
    if (pick < 8) begin
      // Noise: any corner, any span.
      w.cx = 13'($urandom_range(8191));
      w.cy = 13'($urandom_range(8191));
      w.sx = 12'($urandom_range(4095));
      w.sy = 12'($urandom_range(4095));
    end else begin
      w.cx = 13'(near_edge(win_left, win_right));
      w.cy = 13'(near_edge(win_top, win_bottom));
      pick = $urandom_range(99);
      w.sx = 12'((pick < 70) ? $urandom_range(6) : (pick < 92) ? $urandom_range(30)
                 : $urandom_range(4095));
      pick = $urandom_range(99);
      w.sy = 12'((pick < 70) ? $urandom_range(6) : (pick < 92) ? $urandom_range(30)
                 : $urandom_range(4095));
    end
    w.solid = 1'($urandom_range(1));
    w.paint = 24'($urandom);
    return w;
  endfunction

  // Mostly full commands: a start, then advances until it is done or 80 advances are sent.
  // Now and then abandon a command early, or send one more advance, to an idle engine if the command is done.
  task automatic random_run(input int budget);
    draw_word_t w;
    int sent, cap, n;
    sent = 0;
    while (sent < budget) begin
      w = rand_rect();
      put_word(w, 1'b0, NO_RES);
      sent++;
      cap = ($urandom_range(9) == 0) ? $urandom_range(6) : 80;
      n = 0;
      while (draw_phase != PH_IDLE && n < cap) begin
        w = rand_rect();
        w.action = ACT_ADVANCE;
        put_word(w, 1'b0, NO_RES);
        n++;
        sent++;
      end
      if ($urandom_range(9) < 2) begin
        w = rand_rect();
        w.action = ACT_ADVANCE;
        put_word(w, 1'b0, NO_RES);
      end
    end
  endtask

  // Result side: check each taken word against the oldest expectation,
  // then draw the ready for the next cycle.
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result word with nothing expected (word_address %0d)", word_address);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (write_valid !== want.wv) begin
          $error("write_valid: expected %0d, got %0d", want.wv, write_valid);
          error_count++;
        end
        if (word_address !== want.addr) begin
          $error("word_address: expected %0d, got %0d", want.addr, word_address);
          error_count++;
        end
        if (pixel_word !== want.data) begin
          $error("pixel_word: expected %h, got %h", want.data, pixel_word);
          error_count++;
        end
        if (finished !== want.fin) begin
          $error("finished: expected %0d, got %0d", want.fin, finished);
          error_count++;
        end
      end
      results_seen++;
      if (write_valid === 1'b1) writes_seen++;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    // Shadow starts from the reset state.
    win_left   = int'(RST_CLIP_LEFT);
    win_top    = int'(RST_CLIP_TOP);
    win_right  = int'(RST_CLIP_RIGHT);
    win_bottom = int'(RST_CLIP_BOTTOM);
    pitch      = int'(RST_LINE_PITCH);
    draw_phase = PH_IDLE;
    pen_x = 0;
    pen_y = 0;
    col_lo = 0;
    col_hi = 0;
    row_lo = 0;
    row_hi = 0;
    r_left = 0;
    r_right_end = 0;
    r_top = 0;
    r_bottom_end = 0;
    edge_en = '0;
    fill_word = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run in the reset window 0,0..800,480, pitch 800.
    // Advance with nothing running.
    stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b1,
                          mk_res(1'b0, 0, 32'h0, 1'b1)});
    // Rejections: right of window, wholly left, extreme corner, wholly above-left.
    stim_table.push_back({mk_word(ACT_START, 800, 0, 1, 1, 1'b1, 24'h123456), 1'b1,
                          mk_res(1'b0, 0, 32'h0, 1'b1)});
    stim_table.push_back({mk_word(ACT_START, -10, 0, 5, 1, 1'b1, 24'h654321), 1'b1,
                          mk_res(1'b0, 0, 32'h0, 1'b1)});
    stim_table.push_back({mk_word(ACT_START, 4095, 4095, 4095, 4095, 1'b1, 24'hFFFFFF), 1'b1,
                          mk_res(1'b0, 0, 32'h0, 1'b1)});
    stim_table.push_back({mk_word(ACT_START, -4096, -4096, 4095, 4095, 1'b0, 24'h0), 1'b1,
                          mk_res(1'b0, 0, 32'h0, 1'b1)});
    // Two by two fill at the origin, then one advance past its end.
    stim_table.push_back({mk_word(ACT_START, 0, 0, 2, 2, 1'b1, 24'hFFFFFF), 1'b1,
                          mk_res(1'b0, 0, 32'h0, 1'b0)});
    stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b1,
                          mk_res(1'b1, 8, 32'hFFFFFF00, 1'b0)});
    stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b1,
                          mk_res(1'b1, 9, 32'hFFFFFF00, 1'b0)});
    stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b1,
                          mk_res(1'b1, 808, 32'hFFFFFF00, 1'b0)});
    stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b1,
                          mk_res(1'b1, 809, 32'hFFFFFF00, 1'b1)});
    stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b1,
                          mk_res(1'b0, 0, 32'h0, 1'b1)});
    // Zero width fill: accepted but empty.
    stim_table.push_back({mk_word(ACT_START, 5, 5, 0, 3, 1'b1, 24'hABCDEF), 1'b1,
                          mk_res(1'b0, 0, 32'h0, 1'b1)});
    // Bottom edge sits above the window, right edge left of it: both dropped.
    stim_table.push_back({mk_word(ACT_START, 10, -3, 4, 3, 1'b0, 24'h111111), 1'b0, NO_RES});
    stim_table.push_back({mk_word(ACT_START, -3, 10, 3, 4, 1'b0, 24'h222222), 1'b0, NO_RES});
    // Outline hanging off the top-left corner; abandon it part way.
    stim_table.push_back({mk_word(ACT_START, -5, -5, 10, 10, 1'b0, 24'hA5A5A5), 1'b0, NO_RES});
    repeat (4) stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b0,
                                     NO_RES});
    // One by one outline: every edge lands on the same word.
    stim_table.push_back({mk_word(ACT_START, 0, 0, 1, 1, 1'b0, 24'h000001), 1'b0, NO_RES});
    repeat (4) stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b0,
                                     NO_RES});
    // Outline clipped at the bottom-right corner.
    stim_table.push_back({mk_word(ACT_START, 798, 478, 3, 2, 1'b0, 24'h800000), 1'b0, NO_RES});
    repeat (3) stim_table.push_back({mk_word(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 24'h0), 1'b0,
                                     NO_RES});

    foreach (stim_table[i]) put_word(stim_table[i].word, stim_table[i].typed, stim_table[i].res);

    // Random runs, one window per run; idling swaps after the first third and stops in the last.
    for (int run = 0; run < RANDOM_RUNS; run++) begin
      drain();
      case (run / 3)
        0: begin
          send_gap_pct = 27;
          recv_stall_pct = 66;
        end
        1: begin
          send_gap_pct = 66;
          recv_stall_pct = 27;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (run)
        0: set_window(0, 0, 2048, 2048, 2048);
        1: set_window(100, 50, 140, 80, 640);
        2: set_window(4095, 4095, 4095, 4095, 4095);
        3: set_window(300, 20, 200, 200, 0);
        4: set_window($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                      $urandom_range(4095), $urandom_range(4095));
        5: set_window(10, 10, 30, 30, 1);
        7: set_window(2000, 2000, 2048, 2048, 2047);
        default: begin
          win_left = $urandom_range(2000);
          win_top = $urandom_range(2000);
          set_window(win_left, win_top, win_left + $urandom_range(200),
                     win_top + $urandom_range(200), $urandom_range(1, 4095));
        end
      endcase
      random_run(WORDS_PER_RUN);
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d input words over %0d register writes and %0d clip windows;",
             words_in, reg_writes, RANDOM_RUNS + 1);
    $display("checked %0d result words, %0d of them framebuffer writes.",
             results_seen, writes_seen);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
